// ===== rtl/sh_pkg.sv =====
// ----------------------------------------------------------------------------
// sh_pkg: shared types and constants of the SipHash-2-4 hash block
// Holds the lane type, the command record passed from the front to the
// back through the queue, the IV constants and the SipRound function.
// ----------------------------------------------------------------------------
package sh_pkg;

    typedef logic [3:0][63:0] t_lanes;

    // One command: an optional full word to absorb and, on the last request of
    // a message, the final block made of the tail bytes and the length.
    typedef struct packed {
        logic [63:0] word;
        logic [63:0] fin_blk;
        logic        has_word;
        logic        is_final;
        logic        start;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    localparam logic [63:0] KEY_LOW_RST  = 64'h0706050403020100;
    localparam logic [63:0] KEY_HIGH_RST = 64'h0f0e0d0c0b0a0908;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
        c = c + d; d = rotl(d, 16); d = d ^ c;
        a = a + d; d = rotl(d, 21); d = d ^ a;
        c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
        sip_round = {d, c, b, a};
    endfunction

endpackage

// ===== rtl/sh_front.sv =====
// ----------------------------------------------------------------------------
// sh_front: request intake of the SipHash block
// Accepts message words, tracks the byte length and the message start, and
// turns each request into one command for the queue.
// ----------------------------------------------------------------------------
module sh_front
    import sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd,
    output logic        o_stall
);

    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic        r_start;
    logic        n_start;
    logic [3:0]  cnt_sat;
    logic        has_word;
    logic [63:0] tail;
    logic [7:0]  len_add;

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        cnt_sat  = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        has_word = !i_last || (cnt_sat == 4'd8);
        for (int b = 0; b < 8; b++) begin
            tail[8*b +: 8] = (!has_word && (4'(b) < cnt_sat)) ? i_word[8*b +: 8] : 8'h00;
        end
        len_add = has_word ? 8'd8 : {4'b0000, cnt_sat};
        n_len   = r_len + len_add;

        o_cmd.word     = i_word;
        o_cmd.fin_blk  = tail | {n_len, 56'd0};
        o_cmd.has_word = has_word;
        o_cmd.is_final = i_last;
        o_cmd.start    = r_start;

        n_start = o_push ? i_last : r_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= 8'd0;
            r_start <= 1'b1;
        end else begin
            r_start <= n_start;
            if (o_push) begin
                r_len <= i_last ? 8'd0 : n_len;
            end
        end
    end

endmodule

// ===== rtl/sh_queue.sv =====
// ----------------------------------------------------------------------------
// sh_queue: command queue between front and back
// A two-entry first-in first-out buffer of commands.
// ----------------------------------------------------------------------------
module sh_queue
    import sh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_head           = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.not_empty;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> r_rd_ptr != $past(r_rd_ptr) || QUEUE_DEPTH == 1)
        else $error("pop did not advance read pointer");

    a_push_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && do_pop) |=> $stable(r_count))
        else $error("count changed on simultaneous push and pop");

endmodule

// ===== rtl/sh_back.sv =====
// ----------------------------------------------------------------------------
// sh_back: SipRound engine of the SipHash block
// Takes commands from the queue, runs one SipRound per cycle to absorb and
// finalize, the last only into a free output register that holds the hash.
// ----------------------------------------------------------------------------
module sh_back
    import sh_pkg::*;
#(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    input  t_cmd        i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    output logic [63:0] o_hash,
    input  logic        i_stall
);

    localparam int MAX_R = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
    localparam int CW    = $clog2(MAX_R + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ABS,
        S_FINR
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_lanes        r_lanes, n_lanes;
    logic [63:0]   r_msg, n_msg;
    logic [63:0]   r_fin_blk, n_fin_blk;
    logic          r_abs_final, n_abs_final;
    logic          r_fin_pending, n_fin_pending;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_hash, n_hash;

    t_lanes        pre;
    t_lanes        xin;
    t_lanes        rnd;
    t_lanes        done_lanes;
    logic [63:0]   m_cur;
    logic          inject;
    logic          abs_final_cur;
    logic          fin_pending_cur;
    logic [63:0]   fin_blk_cur;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] cnt_inc;
    logic          out_free;

    assign o_valid = r_out_valid;
    assign o_hash  = r_hash;

    always_comb begin
        out_free = !r_out_valid || !i_stall;
        o_pop    = (r_state == S_IDLE) && i_q_stat.not_empty;

        if (r_state == S_IDLE && i_head.start) begin
            pre = {IV3 ^ i_key_high, IV2 ^ i_key_low, IV1 ^ i_key_high, IV0 ^ i_key_low};
        end else begin
            pre = r_lanes;
        end

        if (r_state == S_IDLE) begin
            m_cur           = i_head.has_word ? i_head.word : i_head.fin_blk;
            abs_final_cur   = !i_head.has_word;
            fin_pending_cur = i_head.is_final;
            fin_blk_cur     = i_head.fin_blk;
            cnt_cur         = '0;
        end else begin
            m_cur           = r_msg;
            abs_final_cur   = r_abs_final;
            fin_pending_cur = r_fin_pending;
            fin_blk_cur     = r_fin_blk;
            cnt_cur         = r_cnt;
        end

        // The first round of each absorption folds the block into lane 3.
        inject = (r_state == S_IDLE) || (r_state == S_ABS && r_cnt == '0);
        xin    = pre;
        if (inject) begin
            xin[3] = pre[3] ^ m_cur;
        end
        rnd     = sip_round(xin);
        cnt_inc = cnt_cur + 1'b1;

        done_lanes    = rnd;
        done_lanes[0] = rnd[0] ^ m_cur;
        if (abs_final_cur) begin
            done_lanes[2] = rnd[2] ^ FIN_XOR;
        end

        n_state       = r_state;
        n_cnt         = r_cnt;
        n_lanes       = r_lanes;
        n_msg         = r_msg;
        n_fin_blk     = r_fin_blk;
        n_abs_final   = r_abs_final;
        n_fin_pending = r_fin_pending;
        n_hash        = r_hash;
        n_out_valid   = r_out_valid && i_stall;

        unique case (r_state)
            S_IDLE, S_ABS: begin
                if (r_state == S_ABS || o_pop) begin
                    n_msg         = m_cur;
                    n_fin_blk     = fin_blk_cur;
                    n_abs_final   = abs_final_cur;
                    n_fin_pending = fin_pending_cur;
                    if (cnt_inc == CW'(COMPRESS_ROUNDS)) begin
                        n_lanes = done_lanes;
                        n_cnt   = '0;
                        if (abs_final_cur) begin
                            n_state = S_FINR;
                        end else if (fin_pending_cur) begin
                            n_state     = S_ABS;
                            n_msg       = fin_blk_cur;
                            n_abs_final = 1'b1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_lanes = rnd;
                        n_cnt   = cnt_inc;
                        n_state = S_ABS;
                    end
                end
            end
            S_FINR: begin
                if (cnt_inc == CW'(FINAL_ROUNDS)) begin
                    // The last round waits until the output register is free.
                    if (out_free) begin
                        n_lanes     = rnd;
                        n_hash      = rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];
                        n_out_valid = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_lanes = rnd;
                    n_cnt   = cnt_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lanes   <= n_lanes;
        r_msg     <= n_msg;
        r_fin_blk <= n_fin_blk;
        r_hash    <= n_hash;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_abs_final   <= 1'b0;
            r_fin_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_abs_final   <= n_abs_final;
            r_fin_pending <= n_fin_pending;
            r_out_valid   <= n_out_valid;
        end
    end

    a_new_hash_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && i_stall)) |-> $past(r_state == S_FINR))
        else $error("hash appeared without finalization rounds");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(MAX_R))
        else $error("round counter out of range");

    a_finr_after_final_absorb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINR && $past(r_state) != S_FINR) |-> $past(n_abs_final))
        else $error("finalization entered without final block");

endmodule

// ===== rtl/siphash_2_4_hash.sv =====
// ----------------------------------------------------------------------------
// siphash_2_4_hash: keyed SipHash-2-4 with a 64-bit result
// Top level: key registers on the APB-style port, request front, command
// queue and SipRound engine.
// ----------------------------------------------------------------------------
// A message enters as little-endian 64-bit words, the last one marked and
// carrying 0 to 8 bytes; one hash request leaves per message. The engine runs
// one SipRound per cycle, but the last finalization round waits while the
// output register holds a stalled hash. A full word takes COMPRESS_ROUNDS
// rounds (2 by default); the last word adds COMPRESS_ROUNDS rounds for the
// final block and FINAL_ROUNDS for finalization, plus COMPRESS_ROUNDS more when full.
// A two-entry command queue lets the input side keep taking words while the
// engine works or the hash waits at the output. The key is sampled when a
// message starts; key_low lies at byte address 0 and key_high at 8.
module siphash_2_4_hash
    import sh_pkg::*;
#(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    t_cmd        cmd;
    t_cmd        head;
    t_q_stat     q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? r_key_high : r_key_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= KEY_LOW_RST;
            r_key_high <= KEY_HIGH_RST;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_key_high <= pwdata;
            end else begin
                r_key_low <= pwdata;
            end
        end
    end

    sh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_stall      (o_stall)
    );

    sh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    sh_back #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_hash     (o_hash),
        .i_stall    (i_stall)
    );

endmodule
